>>> rtl/core/dro_pkg.sv
// ----------------------------------------------------------------------------
// dro_pkg
// Shared constants, types and helpers of the dual range obstacle detector.
// ----------------------------------------------------------------------------
package dro_pkg;

  localparam int SAMPLE_WIDTH = 16;
  localparam int RAW_W        = 16;
  localparam int DIST_W       = 13;
  localparam int COUNT_W      = 8;
  localparam int CFG_IDX_W    = 2;

  localparam logic [RAW_W-1:0] SAMPLE_MASK =
    RAW_W'((33'd1 << SAMPLE_WIDTH) - 33'd1);

  // Reserved sensor codes; a window entry holding one of them is not valid.
  localparam logic [RAW_W-1:0] CODE_ZERO     = RAW_W'(0);
  localparam logic [RAW_W-1:0] CODE_TIMEOUT  = RAW_W'(20);
  localparam logic [RAW_W-1:0] CODE_OVERFLOW = RAW_W'(8190);
  localparam logic [RAW_W-1:0] CODE_EMPTY    = RAW_W'(9999);

  localparam int WIN_DEPTH = 3;

  localparam logic [DIST_W-1:0]  STOP_RESET   = DIST_W'(500);
  localparam logic [DIST_W-1:0]  RESUME_RESET = DIST_W'(540);
  localparam logic [COUNT_W-1:0] LIMIT_RESET  = COUNT_W'(5);
  localparam logic [COUNT_W-1:0] COUNT_MAX    = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STOP   = 2'd0,
    REG_RESUME = 2'd1,
    REG_LIMIT  = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [DIST_W-1:0]  stop_distance;
    logic [DIST_W-1:0]  resume_distance;
    logic [COUNT_W-1:0] count_limit;
  } cfg_t;

  typedef struct packed {
    logic detected;
    logic stop_event;
    logic resume_event;
  } det_status_t;

  function automatic logic reading_ok(input logic [RAW_W-1:0] v);
    reading_ok = (v != CODE_ZERO) && (v != CODE_TIMEOUT) &&
                 (v != CODE_OVERFLOW) && (v != CODE_EMPTY);
  endfunction

endpackage

>>> rtl/core/dual_range_obstacle_detector.sv
// ----------------------------------------------------------------------------
// dual_range_obstacle_detector
// Median-of-three range filter per sensor plus obstacle detection hysteresis.
// ----------------------------------------------------------------------------
//
//   channel | ports                                        | beat
//   --------+----------------------------------------------+-----------------
//   in      | in_valid/in_ready, in_left_raw, in_right_raw  | one sensor poll
//   out     | out_valid/out_ready, out_left_distance, ...   | one poll result
//   cfg     | cfg_valid/cfg_ready, cfg_index, cfg_data      | one register
//
// A beat is held in the input register, is processed in a single pass of
// compare logic and lands in the output register, which raises out_valid;
// one beat per cycle is sustained while out_ready stays high. The
// output register can hold a result while the next beat sits in the input
// register; a stall on out backs up into in_ready only when both are full.
// Synchronous active-low reset fills both windows with the empty code 9999
// and clears the counter, the flag and the valid bits. Configuration writes
// are always ready.
// ----------------------------------------------------------------------------
module dual_range_obstacle_detector import dro_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,

  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [RAW_W-1:0]     in_left_raw,
  input  logic [RAW_W-1:0]     in_right_raw,

  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [RAW_W-1:0]     out_left_distance,
  output logic [RAW_W-1:0]     out_right_distance,
  output logic                 out_detected,
  output logic                 out_stop_event,
  output logic                 out_resume_event,

  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIST_W-1:0]    cfg_data
);

  // input register
  logic             in_valid_r;
  logic [RAW_W-1:0] left_raw_r, right_raw_r;

  // output register
  logic             out_valid_r;
  logic [RAW_W-1:0] left_dist_r, right_dist_r;
  det_status_t      status_r;

  cfg_t             cfg_r;
  logic             advance;
  logic [RAW_W-1:0] left_med, right_med;
  det_status_t      status;

  // Process the held beat whenever the result register is free or draining.
  assign advance   = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      left_raw_r  <= in_left_raw;
      right_raw_r <= in_right_raw;
    end
  end

  // Register writes; unknown indexes drop the write.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.stop_distance   <= STOP_RESET;
      cfg_r.resume_distance <= RESUME_RESET;
      cfg_r.count_limit     <= LIMIT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_STOP:   cfg_r.stop_distance   <= cfg_data;
        REG_RESUME: cfg_r.resume_distance <= cfg_data;
        REG_LIMIT:  cfg_r.count_limit     <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  dro_ring u_left (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .raw     (left_raw_r),
    .median  (left_med)
  );

  dro_ring u_right (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .raw     (right_raw_r),
    .median  (right_med)
  );

  dro_hyst u_hyst (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .cfg       (cfg_r),
    .left_med  (left_med),
    .right_med (right_med),
    .status    (status)
  );

  // Hold the result until taken; load a fresh one on every advance.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      left_dist_r  <= left_med;
      right_dist_r <= right_med;
      status_r     <= status;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_left_distance  = left_dist_r;
  assign out_right_distance = right_dist_r;
  assign out_detected       = status_r.detected;
  assign out_stop_event     = status_r.stop_event;
  assign out_resume_event   = status_r.resume_event;

endmodule

>>> rtl/core/dro_ring.sv
// ----------------------------------------------------------------------------
// dro_ring
// Three-entry sample window of one sensor with median of the updated window.
// ----------------------------------------------------------------------------
module dro_ring import dro_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             advance,
  input  logic [RAW_W-1:0] raw,
  output logic [RAW_W-1:0] median
);

  logic [RAW_W-1:0] win_r   [WIN_DEPTH];
  logic [RAW_W-1:0] win_nxt [WIN_DEPTH];
  logic [1:0]       slot_r, slot_nxt;
  logic [RAW_W-1:0] sample;
  logic             put;
  logic [RAW_W-1:0] lo_ab, hi_ab, lo_hc;

  assign sample = raw & SAMPLE_MASK;
  assign put    = reading_ok(sample);

  always_comb begin
    win_nxt  = win_r;
    slot_nxt = slot_r;
    if (put) begin
      case (slot_r)
        2'd1: begin
          win_nxt[1] = sample;
          slot_nxt   = 2'd2;
        end
        2'd2: begin
          win_nxt[2] = sample;
          slot_nxt   = 2'd0;
        end
        default: begin
          win_nxt[0] = sample;
          slot_nxt   = 2'd1;
        end
      endcase
    end
  end

  // median = max(min(a,b), min(max(a,b),c)) on the window after this poll
  always_comb begin
    lo_ab  = (win_nxt[0] < win_nxt[1]) ? win_nxt[0] : win_nxt[1];
    hi_ab  = (win_nxt[0] < win_nxt[1]) ? win_nxt[1] : win_nxt[0];
    lo_hc  = (hi_ab < win_nxt[2]) ? hi_ab : win_nxt[2];
    median = (lo_ab > lo_hc) ? lo_ab : lo_hc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WIN_DEPTH; i++) win_r[i] <= CODE_EMPTY;
      slot_r <= 2'd0;
    end else if (advance) begin
      win_r  <= win_nxt;
      slot_r <= slot_nxt;
    end
  end

endmodule

>>> rtl/core/dro_hyst.sv
// ----------------------------------------------------------------------------
// dro_hyst
// Up/down hit counter and detection flag with hysteresis.
// ----------------------------------------------------------------------------
module dro_hyst import dro_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             advance,
  input  cfg_t             cfg,
  input  logic [RAW_W-1:0] left_med,
  input  logic [RAW_W-1:0] right_med,
  output det_status_t      status
);

  logic [COUNT_W-1:0] count_r, count_nxt, count_step;
  logic               flag_r, flag_nxt, flag_set;
  logic               both_ok, obstacle, clear;
  logic [RAW_W-1:0]   stop_ext, resume_ext;

  assign stop_ext   = RAW_W'(cfg.stop_distance);
  assign resume_ext = RAW_W'(cfg.resume_distance);
  assign both_ok    = reading_ok(left_med) && reading_ok(right_med);
  assign obstacle   = both_ok && ((left_med < stop_ext) || (right_med < stop_ext));

  always_comb begin
    count_step = count_r;
    if (obstacle) begin
      if (count_r != COUNT_MAX) count_step = count_r + COUNT_W'(1);
    end else if (count_r != '0) begin
      count_step = count_r - COUNT_W'(1);
    end
    flag_set = !flag_r && (count_step >= cfg.count_limit);
    clear    = (flag_r || flag_set) && both_ok &&
               (left_med > resume_ext) && (right_med > resume_ext);
    flag_nxt  = (flag_r || flag_set) && !clear;
    count_nxt = clear ? '0 : count_step;
    status.detected     = flag_nxt;
    status.stop_event   = flag_set;
    status.resume_event = clear;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      flag_r  <= 1'b0;
    end else if (advance) begin
      count_r <= count_nxt;
      flag_r  <= flag_nxt;
    end
  end

endmodule

>>> bench/dual_range_obstacle_detector_tb.sv
// ----------------------------------------------------------------------------
// dual_range_obstacle_detector_tb
// Self-checking bench for the median filter and obstacle hysteresis.
// Polls go in through the in channel from a queue, and a local model of the
// two median rings, the hit counter and the detection flag predicts every
// result beat. Thresholds are reprogrammed between phases while the block is
// empty, and each phase uses its own mix of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module dual_range_obstacle_detector_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dro_pkg::*;

  // Index with no register behind it; the block has to ignore the write.
  localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;

  // Give up after this many cycles in which no channel moves a beat.
  localparam int QUIET_LIMIT = 2000;

  typedef struct {
    logic [RAW_W-1:0] left_raw;
    logic [RAW_W-1:0] right_raw;
  } poll_t;

  typedef struct {
    logic [RAW_W-1:0] left_distance;
    logic [RAW_W-1:0] right_distance;
    logic             detected;
    logic             stop_event;
    logic             resume_event;
  } poll_result_t;

  // Shape of a run of random polls: in or just above the stop zone, at or
  // beyond the resume zone, or garbage mixed with reserved sensor codes.
  typedef enum {RUN_NEAR, RUN_FAR, RUN_NOISE} run_kind_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;

  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [RAW_W-1:0]     in_left_raw = '0;
  logic [RAW_W-1:0]     in_right_raw = '0;

  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [RAW_W-1:0]     out_left_distance;
  logic [RAW_W-1:0]     out_right_distance;
  logic                 out_detected;
  logic                 out_stop_event;
  logic                 out_resume_event;

  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DIST_W-1:0]    cfg_data = '0;

  dual_range_obstacle_detector u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_left_raw        (in_left_raw),
    .in_right_raw       (in_right_raw),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_left_distance  (out_left_distance),
    .out_right_distance (out_right_distance),
    .out_detected       (out_detected),
    .out_stop_event     (out_stop_event),
    .out_resume_event   (out_resume_event),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  // 4 ns period.
  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // --------------------------------------------------------------------------
  // Stimulus queue and pacing knobs
  // --------------------------------------------------------------------------
  poll_t        polls_to_send[$];
  poll_result_t poll_results_due[$];

  int in_idle_pct     = 0;   // chance per cycle that the sender holds back
  int out_stall_pct   = 0;   // chance per cycle that the receiver stalls
  int hold_out_cycles = 0;   // long receiver hold-off, counted down below
  int mismatch_count  = 0;
  int quiet_cycles    = 0;
  logic in_acc = 1'b0;       // in beat taken at the last rising edge
  poll_t drv_poll;

  // --------------------------------------------------------------------------
  // Model state: two median rings, hit counter, flag and register copies
  // --------------------------------------------------------------------------
  logic [RAW_W-1:0]   ring [2][WIN_DEPTH];
  int                 slot [2];
  logic [COUNT_W-1:0] hit_count;
  logic               alarm;
  logic [DIST_W-1:0]  stop_thr;
  logic [DIST_W-1:0]  resume_thr;
  logic [COUNT_W-1:0] hit_limit;

  function automatic logic reading_valid(input logic [RAW_W-1:0] v);
    return !(v inside {CODE_ZERO, CODE_TIMEOUT, CODE_OVERFLOW, CODE_EMPTY});
  endfunction

  // Median of three: clamp the third value between the other two.
  function automatic logic [RAW_W-1:0] mid3(input logic [RAW_W-1:0] a, b, c);
    logic [RAW_W-1:0] lo, hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    return (c < lo) ? lo : ((c > hi) ? hi : c);
  endfunction

  // Advance the model by one poll and queue the result it must produce.
  task automatic filter_and_detect(input logic [RAW_W-1:0] left_raw, right_raw);
    logic [RAW_W-1:0] raw [2];
    logic [RAW_W-1:0] med [2];
    logic             both_ok;
    logic             obstacle;
    poll_result_t     r;
    raw[0] = left_raw & SAMPLE_MASK;
    raw[1] = right_raw & SAMPLE_MASK;
    // Store a usable reading at the write slot; drop reserved codes.
    for (int s = 0; s < 2; s++) begin
      if (reading_valid(raw[s])) begin
        ring[s][slot[s]] = raw[s];
        slot[s] = (slot[s] == WIN_DEPTH - 1) ? 0 : slot[s] + 1;
      end
      med[s] = mid3(ring[s][0], ring[s][1], ring[s][2]);
    end
    both_ok  = reading_valid(med[0]) && reading_valid(med[1]);
    obstacle = both_ok && (med[0] < stop_thr || med[1] < stop_thr);
    r.stop_event   = 1'b0;
    r.resume_event = 1'b0;
    // Count up on an obstacle and saturate; otherwise drain toward zero.
    if (obstacle) begin
      if (hit_count != COUNT_MAX) hit_count = hit_count + 1'b1;
    end else if (hit_count != '0) begin
      hit_count = hit_count - 1'b1;
    end
    if (!alarm && hit_count >= hit_limit) begin
      alarm = 1'b1;
      r.stop_event = 1'b1;
    end
    // Set and clear may both fire in one poll.
    if (alarm && both_ok && med[0] > resume_thr && med[1] > resume_thr) begin
      alarm = 1'b0;
      hit_count = '0;
      r.resume_event = 1'b1;
    end
    r.left_distance  = med[0];
    r.right_distance = med[1];
    r.detected       = alarm;
    poll_results_due.push_back(r);
  endtask

  task automatic flag_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  // --------------------------------------------------------------------------
  // Driver: present the next queued poll at the falling edge. Hold valid and
  // payload until the beat is taken, then advance or go idle.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_acc) begin
      if (polls_to_send.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
        drv_poll = polls_to_send.pop_front();
        in_valid     <= 1'b1;
        in_left_raw  <= drv_poll.left_raw;
        in_right_raw <= drv_poll.right_raw;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, or a solid hold-off while one is requested.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_out_cycles > 0) begin
      hold_out_cycles = hold_out_cycles - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= out_stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: sample all three channels at the rising edge. Track register
  // writes, feed accepted polls to the model, check result beats in order.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    in_acc <= rst_n && in_valid && in_ready;
    if (!rst_n) begin
      for (int s = 0; s < 2; s++) begin
        for (int k = 0; k < WIN_DEPTH; k++) ring[s][k] = CODE_EMPTY;
        slot[s] = 0;
      end
      hit_count  = '0;
      alarm      = 1'b0;
      stop_thr   = STOP_RESET;
      resume_thr = RESUME_RESET;
      hit_limit  = LIMIT_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_STOP:   stop_thr   = cfg_data;
          REG_RESUME: resume_thr = cfg_data;
          REG_LIMIT:  hit_limit  = cfg_data[COUNT_W-1:0];
          default:    ;
        endcase
      end
      if (in_valid && in_ready) filter_and_detect(in_left_raw, in_right_raw);
      if (out_valid && out_ready) begin
        if (poll_results_due.size() == 0) begin
          flag_mismatch($sformatf("unexpected result L=%0d R=%0d det=%0b stop=%0b res=%0b",
                                  out_left_distance, out_right_distance, out_detected,
                                  out_stop_event, out_resume_event));
        end else begin
          poll_result_t want;
          want = poll_results_due.pop_front();
          if (out_left_distance !== want.left_distance ||
              out_right_distance !== want.right_distance ||
              out_detected !== want.detected ||
              out_stop_event !== want.stop_event ||
              out_resume_event !== want.resume_event) begin
            flag_mismatch({
              $sformatf("mismatch: want L=%0d R=%0d det=%0b stop=%0b res=%0b",
                        want.left_distance, want.right_distance, want.detected,
                        want.stop_event, want.resume_event),
              $sformatf(", got L=%0d R=%0d det=%0b stop=%0b res=%0b",
                        out_left_distance, out_right_distance, out_detected,
                        out_stop_event, out_resume_event)});
          end
        end
      end
    end
  end

  // Watchdog: drop the run when nothing moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer helpers
  // --------------------------------------------------------------------------
  task automatic push_poll(input logic [RAW_W-1:0] l, r);
    poll_t p;
    p.left_raw  = l;
    p.right_raw = r;
    polls_to_send.push_back(p);
  endtask

  // Wait until every poll is sent and answered, then let the pipe settle.
  task automatic wait_drained();
    while (polls_to_send.size() != 0 || in_valid || poll_results_due.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Raise the write at the falling edge and hold it until it is taken.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIST_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_thresholds(input logic [DIST_W-1:0] stop_d, resume_d, limit_d);
    write_reg(REG_STOP, stop_d);
    write_reg(REG_RESUME, resume_d);
    write_reg(REG_LIMIT, limit_d);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [RAW_W-1:0] reserved_code();
    case ($urandom_range(3))
      0:       return CODE_ZERO;
      1:       return CODE_TIMEOUT;
      2:       return CODE_OVERFLOW;
      default: return CODE_EMPTY;
    endcase
  endfunction

  // Draw one reading for a run, aimed at the current thresholds.
  function automatic logic [RAW_W-1:0] pick_reading(input run_kind_t kind);
    int unsigned stop_hi, far_lo;
    stop_hi = int'(stop_thr) + 20;
    far_lo  = int'(resume_thr);
    if ($urandom_range(99) < 5) return reserved_code();
    case (kind)
      RUN_NEAR: return RAW_W'($urandom_range(stop_hi, 1));
      RUN_FAR:  return RAW_W'($urandom_range(far_lo + 2000, far_lo));
      default:  return ($urandom_range(1)) ? RAW_W'($urandom()) : reserved_code();
    endcase
  endfunction

  // Queue n polls as runs of 1..40 of one kind: near_pct percent near runs,
  // one in ten noise, the rest far.
  task automatic queue_polls(input int n, input int near_pct);
    int        run_left;
    int        roll;
    run_kind_t kind;
    run_left = 0;
    kind     = RUN_NEAR;
    for (int i = 0; i < n; i++) begin
      if (run_left == 0) begin
        roll = $urandom_range(99);
        if (roll < near_pct) kind = RUN_NEAR;
        else if (roll < near_pct + 10) kind = RUN_NOISE;
        else kind = RUN_FAR;
        run_left = $urandom_range(40, 1);
      end
      push_poll(pick_reading(kind), pick_reading(kind));
      run_left--;
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed polls at reset thresholds: reserved codes on both sides, the
    // field extremes, enough close polls to raise detection, then far polls
    // to clear it again.
    push_poll(CODE_ZERO, CODE_TIMEOUT);
    push_poll(CODE_OVERFLOW, CODE_EMPTY);
    push_poll(16'hFFFF, 16'd1);
    repeat (6) push_poll(16'd100, 16'd100);
    push_poll(16'd21, 16'd8191);
    push_poll(16'd10000, 16'd9998);
    repeat (3) push_poll(16'd600, 16'd600);
    wait_drained();

    // Write to an unused index, then a limit whose high bits fall away and
    // leave zero: each poll raises and clears detection in one go.
    write_reg(REG_NONE, 13'h1FFF);
    set_thresholds(13'h1FFF, 13'h0000, 13'h1F00);
    push_poll(16'd700, 16'd700);
    push_poll(16'hFFFF, 16'hFFFF);
    push_poll(16'h8000, 16'h7FFF);
    push_poll(16'h5555, 16'hAAAA);
    wait_drained();

    // Phase A: no idling, default thresholds. Hold the receiver off for a
    // long stretch while the sender keeps offering, so in_ready backs up.
    set_thresholds(13'd500, 13'd540, 13'd5);
    queue_polls(280, 50);
    @(posedge clk);
    hold_out_cycles = 64;
    wait_drained();

    // Phase B: sender idles. Top thresholds and limit; a long run of close
    // polls drives the counter into saturation.
    in_idle_pct = 55;
    set_thresholds(13'h1FFF, 13'h1FFF, 13'd255);
    queue_polls(270, 100);
    queue_polls(60, 50);
    wait_drained();

    // Phase C: receiver stalls. Zero thresholds: nothing is an obstacle and
    // the flag left from phase B clears.
    in_idle_pct   = 0;
    out_stall_pct = 55;
    set_thresholds(13'd0, 13'd0, 13'd1);
    queue_polls(260, 50);
    wait_drained();

    // Phase D: both sides idle now and then, mid-range thresholds.
    in_idle_pct   = 21;
    out_stall_pct = 21;
    set_thresholds(13'd1000, 13'd2000, 13'd3);
    queue_polls(270, 50);
    wait_drained();

    repeat (6) @(posedge clk);
    if (poll_results_due.size() != 0) mismatch_count++;
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
